/* design/rau_pkg.sv */
// Package for the rational arithmetic unit: operation codes, sequencer states and result widths.
`default_nettype none
package rau_pkg;
	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_GT  = 4'd4,
		OP_GE  = 4'd5,
		OP_LT  = 4'd6,
		OP_LE  = 4'd7,
		OP_EQ  = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	localparam int NUM_W = 33;
	localparam int DEN_W = 31;
endpackage
`default_nettype wire

/* design/rational_arithmetic_unit.sv */
// Rational arithmetic unit: cross products, compares, sign fixup and GCD reduction.
//
// Usage: drive op and the four operand fields, pulse start while busy is low.
// The beat is taken at that edge and busy rises until the result is shown.
// The result (res_num, res_den, cmp_true, div_zero) is valid for exactly one
// cycle with done high; the receiver cannot stall, so it must take it then.
// The steps are: the three products (one shared multiplier used three
// times), a preparation step, then a binary GCD loop of one
// subtract-and-shift step per cycle, then two restoring divisions by the
// GCD at one quotient bit per cycle, then a final step to form the result.
// A compare, unused-op, zero-numerator or zero-denominator beat goes from
// preparation straight to the result step, skipping the GCD and divisions.
// A new beat can be taken at the edge that ends the done cycle, so beats
// do not overlap; the GCD and divide loops share a subtractor.
// Reset (arst_n low) returns the sequencer to idle and clears done and busy.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [3:0]  op,
	input  wire logic signed [15:0] a_num,
	input  wire logic signed [15:0] a_den,
	input  wire logic signed [15:0] b_num,
	input  wire logic signed [15:0] b_den,
	output logic signed [rau_pkg::NUM_W-1:0] res_num,
	output logic [rau_pkg::DEN_W-1:0]        res_den,
	output logic             cmp_true,
	output logic             div_zero
);
	import rau_pkg::*;

	localparam int OW = OPERAND_WIDTH;
	localparam int PW = 2 * OW;       // product magnitude width
	localparam int SW = PW + 1;       // sum magnitude width
	localparam int CW = $clog2(SW + 1);

	state_t state_q, state_d;

	// operand magnitudes and signs
	logic [OW-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [3:0]    op_q;
	logic [1:0]    mphase_q;
	logic [PW-1:0] p0_q, p1_q, p2_q;  // an*bd (an*bn for mul), ad*bn, ad*bd
	logic [SW-1:0] nm_q, dm_q;        // result magnitudes
	logic          neg_q;
	logic [SW-1:0] gx_q, gy_q;        // gcd working pair
	logic [CW-1:0] gk_q;              // common power of two
	logic [SW-1:0] g_q;
	logic [SW-1:0] rem_q, quo_q;
	logic [CW-1:0] cnt_q;

	// sign-magnitude from raw operand bits
	function automatic logic [OW:0] sm(input logic [15:0] raw);
		logic [OW-1:0] v;
		logic          s;
		v = OW'(raw);
		s = v[OW-1];
		return {s, s ? (OW'(0) - v) : v};
	endfunction

	logic [OW:0] an_c, ad_c, bn_c, bd_c;
	assign an_c = sm(a_num);
	assign ad_c = sm(a_den);
	assign bn_c = sm(b_num);
	assign bd_c = sm(b_den);

	// shared multiplier, one product per phase
	logic [OW-1:0] mx, my;
	logic [PW-1:0] mp;
	always_comb begin
		unique case (mphase_q)
			2'd0: begin
				mx = an_m_q;
				my = (op_q == OP_MUL) ? bn_m_q : bd_m_q;
			end
			2'd1: begin
				mx = ad_m_q;
				my = bn_m_q;
			end
			default: begin
				mx = ad_m_q;
				my = bd_m_q;
			end
		endcase
	end
	assign mp = mx * my;

	// signs of products
	logic s_anbd, s_adbn, s_den, s_anbn, in_zero;
	assign s_anbd = an_s_q ^ bd_s_q;
	assign s_adbn = ad_s_q ^ bn_s_q;
	assign s_anbn = an_s_q ^ bn_s_q;
	assign s_den  = ad_s_q ^ bd_s_q;
	assign in_zero = (ad_m_q == '0) || (bd_m_q == '0);

	// preparation: numerator and denominator magnitudes, sign, divide-by-zero flag, compare result
	logic [SW-1:0] pn, pd;
	logic          pneg, pnum_s, pden_s, tsign, cmpv, dzv;
	logic [SW-1:0] x0, x1;
	always_comb begin
		x0 = SW'(p0_q);
		x1 = SW'(p1_q);
		pnum_s = 1'b0;
		pden_s = s_den;
		pn = '0;
		pd = SW'(p2_q);
		tsign = s_adbn ^ (op_q == OP_SUB);
		unique case (op_q)
			OP_ADD, OP_SUB: begin
				if (s_anbd == tsign) begin
					pn = x0 + x1;
					pnum_s = s_anbd;
				end else if (x0 >= x1) begin
					pn = x0 - x1;
					pnum_s = s_anbd;
				end else begin
					pn = x1 - x0;
					pnum_s = tsign;
				end
			end
			OP_MUL: begin
				pn = x0;
				pnum_s = s_anbn;
			end
			OP_DIV: begin
				pn = x0;
				pnum_s = s_anbd;
				pd = x1;
				pden_s = s_adbn;
			end
			default: ;
		endcase
		pneg = (pn != '0) && (pnum_s != pden_s);
		dzv = in_zero || (pd == '0);
		// compare: sign of cross products after making denominators positive
		begin
			logic xs, ys;
			logic gt, eq;
			xs = (p0_q != '0) && (an_s_q ^ ad_s_q);
			ys = (p1_q != '0) && (bn_s_q ^ bd_s_q);
			eq = (xs == ys) && (p0_q == p1_q);
			if (xs != ys) gt = ys;
			else if (xs) gt = p0_q < p1_q;
			else gt = p0_q > p1_q;
			unique case (op_q)
				OP_GT:   cmpv = gt;
				OP_GE:   cmpv = gt || eq;
				OP_LT:   cmpv = !gt && !eq;
				OP_LE:   cmpv = !gt;
				default: cmpv = eq;
			endcase
		end
	end

	// shared subtractor for gcd and division steps (the gcd gy-gx case uses its own)
	logic [SW-1:0] sa, sb, sd;
	logic          sc;
	logic [SW-1:0] rsh;
	always_comb begin
		sa = gx_q;
		sb = gy_q;
		rsh = {rem_q[SW-2:0], quo_q[SW-1]};
		if (state_q == ST_DIVN || state_q == ST_DIVD) begin
			sa = rsh;
			sb = g_q;
		end
	end
	assign {sc, sd} = {1'b0, sa} - {1'b0, sb};

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_MUL;
			ST_MUL:  if (mphase_q == 2'd2) state_d = ST_PREP;
			ST_PREP: begin
				if (op_q > OP_DIV || dzv || pn == '0) state_d = ST_DONE;
				else state_d = ST_GCD;
			end
			ST_GCD:  if (gx_q == '0 || gy_q == '0) state_d = ST_DIVN;
			ST_DIVN: if (cnt_q == CW'(SW - 1)) state_d = ST_DIVD;
			ST_DIVD: if (cnt_q == CW'(SW - 1)) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mphase_q <= 2'd0;
			done     <= 1'b0;
		end else begin
			state_q  <= state_d;
			mphase_q <= (state_q == ST_MUL) ? mphase_q + 2'd1 : 2'd0;
			done     <= (state_q == ST_DONE);
		end
	end
	assign busy = (state_q != ST_IDLE);

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (start) begin
				{an_s_q, an_m_q} <= an_c;
				{ad_s_q, ad_m_q} <= ad_c;
				{bn_s_q, bn_m_q} <= bn_c;
				{bd_s_q, bd_m_q} <= bd_c;
				op_q <= op;
			end
			ST_MUL: begin
				unique case (mphase_q)
					2'd0:    p0_q <= mp;
					2'd1:    p1_q <= mp;
					default: p2_q <= mp;
				endcase
			end
			ST_PREP: begin
				nm_q <= pn;
				dm_q <= pd;
				neg_q <= pneg;
				gx_q <= pn;
				gy_q <= pd;
				gk_q <= '0;
				cnt_q <= '0;
				res_num <= '0;
				res_den <= (op_q <= OP_DIV && dzv) ? 31'd0 : 31'd1;
				div_zero <= (op_q <= OP_DIV) ? dzv : (op_q <= OP_EQ) && in_zero;
				cmp_true <= (op_q > OP_DIV) && (op_q <= OP_EQ) && !in_zero && cmpv;
			end
			ST_GCD: begin
				// binary gcd: strip common twos, then subtract
				if (gx_q == '0 || gy_q == '0) begin
					g_q <= (gx_q | gy_q) << gk_q;
					quo_q <= nm_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					gk_q <= gk_q + 1'b1;
				end else if (!gx_q[0]) gx_q <= gx_q >> 1;
				else if (!gy_q[0]) gy_q <= gy_q >> 1;
				else if (!sc) gx_q <= sd >> 1;
				else gy_q <= (gy_q - gx_q) >> 1;
			end
			ST_DIVN, ST_DIVD: begin
				// restoring division, one quotient bit a cycle
				if (cnt_q == CW'(SW - 1)) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (state_q == ST_DIVN) begin
						nm_q <= {quo_q[SW-2:0], !sc};
						quo_q <= dm_q;
					end else begin
						dm_q <= {quo_q[SW-2:0], !sc};
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (!sc) begin
						rem_q <= sd;
						quo_q <= {quo_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= rsh;
						quo_q <= {quo_q[SW-2:0], 1'b0};
					end
				end
			end
			ST_DONE: begin
				if (op_q <= OP_DIV && !div_zero) begin
					res_num <= neg_q ? 33'(-$signed({1'b0, nm_q}))
						: 33'($signed({1'b0, nm_q}));
					res_den <= (nm_q == '0) ? 31'd1 : 31'(dm_q);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire
